// ----- rtl/core/mvn_pkg.sv -----
// Shared types and constants for the mesh vertex normal engine.
`timescale 1ns / 1ps
`default_nettype none
package mvn_pkg;

  // Defaults for the top-level parameters
  localparam int MVN_MAX_VERTICES = 1024;
  localparam int MVN_COORD_BITS   = 16;
  localparam int MVN_ACCUM_BITS   = 48;

  // Fixed field widths
  localparam int IDX_W   = 10;
  localparam int FIELD_W = 16;
  localparam int NORM_W  = 16;

  // Normalization arithmetic
  localparam int MAG_W   = 30;   // the largest normalized magnitude lies in [2^29, 2^30)
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ROOT_W  = SQ_W + 2;
  localparam int LEN_W   = MAG_W + 1;
  localparam int FRAC_W  = 14;
  localparam int QUO_W   = FRAC_W + 1;
  localparam int REM_W   = MAG_W + FRAC_W + 2;
  localparam int STEP_W  = 5;
  localparam int SQRT_LAST = LEN_W - 1;
  localparam int DIV_LAST  = QUO_W - 1;
  localparam logic [NORM_W-1:0] ONE_Q14 = NORM_W'(1 << FRAC_W);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } mvn_op_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_WRITE,
    DP_POS_RD,
    DP_DIFF,
    DP_CROSS,
    DP_ACC_RD,
    DP_ACC_WR,
    DP_MAG,
    DP_NORM,
    DP_SQ,
    DP_SQRT,
    DP_DINIT,
    DP_DIV,
    DP_DFIN,
    DP_PUBLISH
  } mvn_dp_op_t;

  typedef struct packed {
    mvn_dp_op_t        op;
    logic [1:0]        sel;
    logic [STEP_W-1:0] step;
  } mvn_cmd_t;

  typedef struct packed {
    mvn_op_t op;
    logic    a_ok;
    logic    tri_ok;
    logic    zero;
    logic    norm_busy;
    logic    clr_last;
  } mvn_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/mvn_in_if.sv -----
// Input item channel: operation, indices and position.
`timescale 1ns / 1ps
`default_nettype none
interface mvn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  first_index;
  logic [9:0]  second_index;
  logic [9:0]  third_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;

  modport source (output valid, operation, first_index, second_index, third_index,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, operation, first_index, second_index, third_index,
                pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mvn_out_if.sv -----
// Result item channel: unit normal and zero-length flag.
`timescale 1ns / 1ps
`default_nettype none
interface mvn_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic        zero_length;

  modport source (output valid, normal_x, normal_y, normal_z, zero_length, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, zero_length, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mesh_vertex_normal_engine.sv -----
// Top level of the mesh vertex normal engine.
`timescale 1ns / 1ps
`default_nettype none
// Area-weighted vertex normal engine. Write items store a vertex position and clear its
// normal accumulator; add-triangle items add the unnormalized face normal (B-A)x(C-A) into
// the saturating accumulators of all three corners; read items return the vertex's unit
// normal in signed Q1.14 with a zero-length flag. Every item yields exactly one result item.
// One item is worked on at a time, through a single-port-per-side position RAM and
// accumulator RAM and one shared multiplier per phase: an add triangle makes three
// position reads, six serial multiplies and three read-modify-writes, and a read makes
// a one-bit-per-cycle magnitude normalization, 31 square-root iterations and three
// 15-step divisions. A new item is taken while the previous result still waits at the
// output. After reset all MAX_VERTICES accumulator entries are cleared, one entry per
// cycle, before the first item is accepted.
module mesh_vertex_normal_engine #(
  parameter int MAX_VERTICES = mvn_pkg::MVN_MAX_VERTICES,
  parameter int COORD_BITS   = mvn_pkg::MVN_COORD_BITS,
  parameter int ACCUM_BITS   = mvn_pkg::MVN_ACCUM_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  mvn_in_if.sink   in_chan,
  mvn_out_if.source out_chan
);
  import mvn_pkg::*;

  mvn_cmd_t cmd;
  mvn_sts_t sts;
  logic     load;

  mvn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .sts(sts), .cmd(cmd), .load(load)
  );

  mvn_dp #(
    .MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS), .ACCUM_BITS(ACCUM_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .load(load),
    .operation(in_chan.operation),
    .first_index(in_chan.first_index),
    .second_index(in_chan.second_index),
    .third_index(in_chan.third_index),
    .pos_x(in_chan.pos_x), .pos_y(in_chan.pos_y), .pos_z(in_chan.pos_z),
    .cmd(cmd), .sts(sts),
    .normal_x(out_chan.normal_x), .normal_y(out_chan.normal_y),
    .normal_z(out_chan.normal_z), .zero_length(out_chan.zero_length)
  );
endmodule
`default_nettype wire

// ----- rtl/core/mvn_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/mvn_ctrl.sv -----
// Controller state machine: sequences each item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module mvn_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire mvn_pkg::mvn_sts_t sts,
  output mvn_pkg::mvn_cmd_t    cmd,
  output logic                 load
);
  import mvn_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_WRITE, S_POS_RD, S_DIFF, S_CROSS,
    S_ACC_RD, S_ACC_WR, S_RD_ACC, S_MAG, S_NORM, S_SQ, S_SQRT,
    S_DINIT, S_DIV, S_DFIN, S_RESULT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pub_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign load      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign pub_ok    = !out_valid_r || out_ready;

  always_comb begin
    cmd.sel  = sel_r;
    cmd.step = step_r;
    case (state_r)
      S_CLEAR:  cmd.op = DP_CLEAR;
      S_WRITE:  cmd.op = DP_WRITE;
      S_POS_RD: cmd.op = DP_POS_RD;
      S_DIFF:   cmd.op = DP_DIFF;
      S_CROSS:  cmd.op = DP_CROSS;
      S_ACC_RD: cmd.op = DP_ACC_RD;
      S_RD_ACC: cmd.op = DP_ACC_RD;
      S_ACC_WR: cmd.op = DP_ACC_WR;
      S_MAG:    cmd.op = DP_MAG;
      S_NORM:   cmd.op = DP_NORM;
      S_SQ:     cmd.op = DP_SQ;
      S_SQRT:   cmd.op = DP_SQRT;
      S_DINIT:  cmd.op = DP_DINIT;
      S_DIV:    cmd.op = DP_DIV;
      S_DFIN:   cmd.op = DP_DFIN;
      S_RESULT: cmd.op = pub_ok ? DP_PUBLISH : DP_NOP;
      default:  cmd.op = DP_NOP;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (load) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        step_nxt  = '0;
        sel_nxt   = '0;
        state_nxt = S_RESULT;
        case (sts.op)
          OP_WRITE: if (sts.a_ok) state_nxt = S_WRITE;
          OP_ADD:   if (sts.tri_ok) state_nxt = S_POS_RD;
          OP_READ:  if (sts.a_ok) state_nxt = S_RD_ACC;
          default:  state_nxt = S_RESULT;
        endcase
      end
      S_WRITE: state_nxt = S_RESULT;
      S_POS_RD: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(3)) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        step_nxt  = '0;
        state_nxt = S_CROSS;
      end
      S_CROSS: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(6)) begin
          state_nxt = S_ACC_RD;
        end
      end
      S_ACC_RD: state_nxt = S_ACC_WR;
      S_ACC_WR: begin
        if (sel_r == 2'd2) begin
          state_nxt = S_RESULT;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_ACC_RD;
        end
      end
      S_RD_ACC: state_nxt = S_MAG;
      S_MAG:    state_nxt = S_NORM;
      S_NORM: begin
        step_nxt = '0;
        if (sts.zero) begin
          state_nxt = S_RESULT;
        end else if (!sts.norm_busy) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(3)) begin
          step_nxt  = STEP_W'(SQRT_LAST);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          sel_nxt   = '0;
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        step_nxt  = STEP_W'(DIV_LAST);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        if (sel_r == 2'd2) begin
          state_nxt = S_RESULT;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_DINIT;
        end
      end
      S_RESULT: begin
        if (pub_ok) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/mvn_dp.sv -----
// Datapath: vertex tables, cross product, accumulation and normalization.
`timescale 1ns / 1ps
`default_nettype none
module mvn_dp #(
  parameter int MAX_VERTICES = mvn_pkg::MVN_MAX_VERTICES,
  parameter int COORD_BITS   = mvn_pkg::MVN_COORD_BITS,
  parameter int ACCUM_BITS   = mvn_pkg::MVN_ACCUM_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic [1:0]                operation,
  input  wire logic [mvn_pkg::IDX_W-1:0] first_index,
  input  wire logic [mvn_pkg::IDX_W-1:0] second_index,
  input  wire logic [mvn_pkg::IDX_W-1:0] third_index,
  input  wire logic signed [mvn_pkg::FIELD_W-1:0] pos_x,
  input  wire logic signed [mvn_pkg::FIELD_W-1:0] pos_y,
  input  wire logic signed [mvn_pkg::FIELD_W-1:0] pos_z,
  input  wire mvn_pkg::mvn_cmd_t         cmd,
  output mvn_pkg::mvn_sts_t              sts,
  output logic signed [mvn_pkg::NORM_W-1:0] normal_x,
  output logic signed [mvn_pkg::NORM_W-1:0] normal_y,
  output logic signed [mvn_pkg::NORM_W-1:0] normal_z,
  output logic                           zero_length
);
  import mvn_pkg::*;

  localparam int LW = $clog2(MAX_VERTICES);
  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int AW = ACCUM_BITS;
  localparam int SW = ((AW > NW) ? AW : NW) + 1;
  localparam logic signed [SW-1:0] ACC_HI = SW'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [SW-1:0] ACC_LO = -ACC_HI - SW'(1);

  mvn_op_t              op_r;
  logic                 a_ok_r, tri_ok_r;
  logic [LW-1:0]        ia_r, ib_r, ic_r;
  logic signed [CW-1:0] wx_r, wy_r, wz_r;
  logic [LW-1:0]        clr_addr_r;

  logic signed [CW-1:0] posv_r [3][3];
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] w_r [3];
  logic signed [PW-1:0] prod_r;
  logic signed [NW-1:0] nrm_r [3];

  logic [AW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic [SQ_W-1:0]      sqp_r;
  logic [ROOT_W-1:0]    root_rem_r, root_r;
  logic [REM_W-1:0]     div_rem_r;
  logic [QUO_W-1:0]     quo_r;
  logic signed [NORM_W-1:0] res_n_r [3];
  logic                 res_zl_r;
  logic signed [NORM_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                 out_zl_r;

  // memories
  logic                 pos_we, acc_we;
  logic [LW-1:0]        pos_waddr, pos_raddr, acc_waddr, acc_raddr;
  logic [3*CW-1:0]      pos_wdata, pos_rdata;
  logic [3*AW-1:0]      acc_wdata, acc_rdata;

  mvn_ram #(.WIDTH(3*CW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  mvn_ram #(.WIDTH(3*AW), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  function automatic logic [LW-1:0] corner(input logic [1:0] s, input logic [LW-1:0] a,
                                           input logic [LW-1:0] b, input logic [LW-1:0] c);
    case (s)
      2'd1:    corner = b;
      2'd2:    corner = c;
      default: corner = a;
    endcase
  endfunction

  logic [LW-1:0] sel_addr;
  assign sel_addr  = corner(cmd.sel, ia_r, ib_r, ic_r);
  assign pos_raddr = corner(cmd.step[1:0], ia_r, ib_r, ic_r);
  assign acc_raddr = sel_addr;

  // saturating accumulate of the face normal
  logic signed [AW-1:0] acc_old [3];
  logic signed [AW-1:0] acc_new [3];
  logic signed [SW-1:0] acc_sum [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_old[k] = acc_rdata[(2-k)*AW +: AW];
      acc_sum[k] = SW'(acc_old[k]) + SW'(nrm_r[k]);
      if (acc_sum[k] > ACC_HI) begin
        acc_new[k] = AW'(ACC_HI);
      end else if (acc_sum[k] < ACC_LO) begin
        acc_new[k] = AW'(ACC_LO);
      end else begin
        acc_new[k] = AW'(acc_sum[k]);
      end
    end
  end

  always_comb begin
    pos_we    = (cmd.op == DP_WRITE);
    pos_waddr = ia_r;
    pos_wdata = {wx_r, wy_r, wz_r};
    acc_we    = 1'b0;
    acc_waddr = ia_r;
    acc_wdata = '0;
    case (cmd.op)
      DP_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr_r;
      end
      DP_WRITE: acc_we = 1'b1;
      DP_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = sel_addr;
        acc_wdata = {acc_new[0], acc_new[1], acc_new[2]};
      end
      default: acc_we = 1'b0;
    endcase
  end

  // cross product operand schedule: nx = u1*w2 - u2*w1, ny = u2*w0 - u0*w2, nz = u0*w1 - u1*w0
  logic [1:0] cu, cw;
  always_comb begin
    case (cmd.step)
      STEP_W'(0): begin cu = 2'd1; cw = 2'd2; end
      STEP_W'(1): begin cu = 2'd2; cw = 2'd1; end
      STEP_W'(2): begin cu = 2'd2; cw = 2'd0; end
      STEP_W'(3): begin cu = 2'd0; cw = 2'd2; end
      STEP_W'(4): begin cu = 2'd0; cw = 2'd1; end
      default:    begin cu = 2'd1; cw = 2'd0; end
    endcase
  end

  logic [STEP_W-1:0] step_m1;
  assign step_m1 = cmd.step - 1'b1;

  // magnitude shift status
  logic [AW-1:0] mag_or;
  logic          shr, shl;
  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];
  assign shr    = |mag_or[AW-1:MAG_W];
  assign shl    = !shr && !mag_or[MAG_W-1] && (mag_or != '0);

  // root and divide steps
  logic [ROOT_W-1:0] root_bit, root_try;
  logic [LEN_W-1:0]  len;
  logic [REM_W-1:0]  div_try;
  logic [NORM_W-1:0] quo_ext, quo_sat;
  assign root_bit = ROOT_W'(1) << {cmd.step, 1'b0};
  assign root_try = root_r + root_bit;
  assign len      = root_r[LEN_W-1:0];
  assign div_try  = REM_W'(len) << cmd.step[3:0];
  assign quo_ext  = NORM_W'(quo_r);
  assign quo_sat  = (quo_ext > ONE_Q14) ? ONE_Q14 : quo_ext;

  logic a_ok_in, b_ok_in, c_ok_in;
  assign a_ok_in = (32'(first_index) < 32'(MAX_VERTICES));
  assign b_ok_in = (32'(second_index) < 32'(MAX_VERTICES));
  assign c_ok_in = (32'(third_index) < 32'(MAX_VERTICES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.op == DP_CLEAR) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r     <= mvn_op_t'(operation);
      ia_r     <= LW'(first_index);
      ib_r     <= LW'(second_index);
      ic_r     <= LW'(third_index);
      a_ok_r   <= a_ok_in;
      tri_ok_r <= a_ok_in && b_ok_in && c_ok_in;
      wx_r     <= CW'(pos_x);
      wy_r     <= CW'(pos_y);
      wz_r     <= CW'(pos_z);
      for (int k = 0; k < 3; k++) begin
        res_n_r[k] <= '0;
      end
      res_zl_r <= (mvn_op_t'(operation) == OP_READ) && !a_ok_in;
    end
    case (cmd.op)
      DP_POS_RD: begin
        if (cmd.step != '0) begin
          posv_r[step_m1[1:0]][0] <= pos_rdata[2*CW +: CW];
          posv_r[step_m1[1:0]][1] <= pos_rdata[CW +: CW];
          posv_r[step_m1[1:0]][2] <= pos_rdata[0 +: CW];
        end
      end
      DP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          u_r[k] <= DW'(posv_r[1][k]) - DW'(posv_r[0][k]);
          w_r[k] <= DW'(posv_r[2][k]) - DW'(posv_r[0][k]);
        end
      end
      DP_CROSS: begin
        prod_r <= PW'(u_r[cu]) * PW'(w_r[cw]);
        if (cmd.step != '0) begin
          if (step_m1[0]) begin
            nrm_r[step_m1[2:1]] <= nrm_r[step_m1[2:1]] - NW'(prod_r);
          end else begin
            nrm_r[step_m1[2:1]] <= NW'(prod_r);
          end
        end
      end
      DP_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= acc_old[k][AW-1];
          mag_r[k] <= acc_old[k][AW-1] ? AW'(-acc_old[k]) : AW'(acc_old[k]);
        end
      end
      DP_NORM: begin
        for (int k = 0; k < 3; k++) begin
          if (shr) begin
            mag_r[k] <= mag_r[k] >> 1;
          end else if (shl) begin
            mag_r[k] <= mag_r[k] << 1;
          end
        end
      end
      DP_SQ: begin
        if (cmd.step < STEP_W'(3)) begin
          sqp_r <= SQ_W'(mag_r[cmd.step[1:0]][MAG_W-1:0]) *
                   SQ_W'(mag_r[cmd.step[1:0]][MAG_W-1:0]);
        end
        if (cmd.step == '0) begin
          root_rem_r <= '0;
          root_r     <= '0;
        end else begin
          root_rem_r <= root_rem_r + ROOT_W'(sqp_r);
        end
      end
      DP_SQRT: begin
        if (root_rem_r >= root_try) begin
          root_rem_r <= root_rem_r - root_try;
          root_r     <= (root_r >> 1) + root_bit;
        end else begin
          root_r     <= root_r >> 1;
        end
      end
      DP_DINIT: begin
        div_rem_r <= REM_W'({mag_r[cmd.sel][MAG_W-1:0], {FRAC_W{1'b0}}}) +
                     REM_W'(len >> 1);
        quo_r     <= '0;
      end
      DP_DIV: begin
        if (div_rem_r >= div_try) begin
          div_rem_r              <= div_rem_r - div_try;
          quo_r[cmd.step[3:0]]   <= 1'b1;
        end
      end
      DP_DFIN: begin
        res_n_r[cmd.sel] <= neg_r[cmd.sel] ? -$signed(quo_sat) : $signed(quo_sat);
      end
      DP_PUBLISH: begin
        out_x_r  <= res_n_r[0];
        out_y_r  <= res_n_r[1];
        out_z_r  <= res_n_r[2];
        out_zl_r <= res_zl_r;
      end
      default: begin
      end
    endcase
    // a read of an all-zero accumulator gives a zero-length result
    if (cmd.op == DP_NORM && mag_or == '0) begin
      res_zl_r <= 1'b1;
    end
  end

  assign sts.op        = op_r;
  assign sts.a_ok      = a_ok_r;
  assign sts.tri_ok    = tri_ok_r;
  assign sts.zero      = (mag_or == '0);
  assign sts.norm_busy = shr || shl;
  assign sts.clr_last  = (clr_addr_r == LW'(MAX_VERTICES - 1));

  assign normal_x    = out_x_r;
  assign normal_y    = out_y_r;
  assign normal_z    = out_z_r;
  assign zero_length = out_zl_r;
endmodule
`default_nettype wire

// ----- rtl/core/mvn_checker.sv -----
// Port-level checker for the mesh vertex normal engine, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module mvn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic signed [15:0] normal_x,
  input wire logic signed [15:0] normal_y,
  input wire logic signed [15:0] normal_z,
  input wire logic        zero_length
);
  // a waiting result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn before it was taken");

  // zero-length results carry a zero vector
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_length |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("zero-length result with nonzero normal");

  // components stay within one in Q1.14
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> normal_x <= 16384 && normal_x >= -16384 &&
                  normal_y <= 16384 && normal_y >= -16384 &&
                  normal_z <= 16384 && normal_z >= -16384)
    else $error("normal component out of range");

  // a result item is not raised straight after the acceptance of an item
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result item appeared in the cycle after acceptance");
endmodule

bind mesh_vertex_normal_engine mvn_checker u_mvn_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_chan.valid), .in_ready(in_chan.ready),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .normal_x(out_chan.normal_x), .normal_y(out_chan.normal_y),
  .normal_z(out_chan.normal_z), .zero_length(out_chan.zero_length)
);
`default_nettype wire
